// ===== design/ghst_pkg.sv =====
// Shared types for the generational handle slot table: command codes and control links.
package ghst_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_code_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;          // take an input beat, start the slot read
        logic handle_finish; // finish lookup or release
        logic add_step;      // scanned slot busy, read the next one
        logic add_reuse;     // scanned slot free, claim it
        logic add_append;    // nothing free below the mark, append or fail
        logic clear;         // empty the table
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // result register can take a beat this cycle
        logic scan_end;  // scan pointer reached the high-water mark
        logic slot_free; // slot under the scan pointer is free
    } dp_status_t;

endpackage

// ===== design/ghst_ctrl.sv =====
// Controller state machine for the generational handle slot table.
module ghst_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  ghst_pkg::cmd_code_t   command,
    input  ghst_pkg::dp_status_t  status,
    output logic                  in_stall,
    output ghst_pkg::ctrl_cmd_t   cmd
);
    import ghst_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_HANDLE = 4'b0010,
        ST_ADD    = 4'b0100,
        ST_CLEAR  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Input side is open only between operations
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (command)
                        CMD_ADD:     state_next = ST_ADD;
                        CMD_LOOKUP:  state_next = ST_HANDLE;
                        CMD_RELEASE: state_next = ST_HANDLE;
                        CMD_CLEAR:   state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HANDLE:
            begin
                if (status.out_free)
                begin
                    cmd.handle_finish = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                if (status.scan_end)
                begin
                    if (status.out_free)
                    begin
                        cmd.add_append = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (!status.slot_free)
                begin
                    cmd.add_step = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.add_reuse = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (status.out_free)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ghst_datapath.sv =====
// Datapath for the generational handle slot table: slot memory, mark, hint and result register.
module ghst_datapath
#(
    parameter int NUM_SLOTS  = 64,
    parameter int EPOCH_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ghst_pkg::ctrl_cmd_t   cmd,
    output ghst_pkg::dp_status_t  status,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    input  ghst_pkg::cmd_code_t   command,
    input  logic [5:0]            handle_slot,
    input  logic [15:0]           handle_epoch,
    input  logic [7:0]            handle_type,
    input  logic [31:0]           item_count,
    input  logic [15:0]           item_stride,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic                  ok,
    output logic [5:0]            out_slot,
    output logic [15:0]           out_epoch,
    output logic [31:0]           out_item_count,
    output logic [15:0]           out_item_stride
);
    import ghst_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int SW     = (CNT_W > 6) ? CNT_W : 6;
    localparam int EW     = (EPOCH_BITS > 16) ? EPOCH_BITS : 16;
    localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);
    localparam logic [CNT_W-1:0]      CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]      CNT_FULL  = CNT_W'(NUM_SLOTS);

    typedef struct packed {
        logic                  busy;
        logic [EPOCH_BITS-1:0] epoch;
        logic [31:0]           count;
        logic [15:0]           stride;
    } entry_t;

    // Slot memory; contents of entries at or above the mark are never used
    entry_t mem [NUM_SLOTS];
    entry_t rdata_reg;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    entry_t                mem_wdata;

    // Control state
    logic [7:0]       exp_type_reg;
    logic [CNT_W-1:0] hw_reg;
    logic [CNT_W-1:0] hw_next;
    logic [CNT_W-1:0] hint_reg;
    logic [CNT_W-1:0] hint_next;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;
    logic             out_valid_reg;

    // Latched input beat
    cmd_code_t   cmd_reg;
    logic [5:0]  hslot_reg;
    logic [15:0] hepoch_reg;
    logic [7:0]  htype_reg;
    logic [31:0] count_reg;
    logic [15:0] stride_reg;

    // Result register payload
    logic        ok_reg;
    logic [5:0]  slot_reg;
    logic [15:0] epoch_reg;
    logic [31:0] ocount_reg;
    logic [15:0] ostride_reg;

    // Result being formed
    logic                  res_load;
    logic                  res_ok;
    logic [SW-1:0]         res_slot;
    logic [EPOCH_BITS-1:0] res_epoch;
    logic [31:0]           res_count;
    logic [15:0]           res_stride;

    // Handle checks
    logic [SW-1:0]         hslot_w;
    logic [SW-1:0]         hw_w;
    logic [SW-1:0]         hint_w;
    logic                  pre_ok;
    logic                  live;
    logic [EPOCH_BITS-1:0] epoch_inc;
    logic [EPOCH_BITS-1:0] epoch_rel;
    logic [EPOCH_BITS-1:0] epoch_reuse;
    logic [EW-1:0]         res_epoch_w;

    always_comb
    begin
        hslot_w     = SW'(hslot_reg);
        hw_w        = SW'(hw_reg);
        hint_w      = SW'(hint_reg);
        pre_ok      = (hepoch_reg != 16'd0) && (htype_reg == exp_type_reg)
                      && (hslot_w != '0) && (hslot_w < hw_w);
        live        = pre_ok && rdata_reg.busy
                      && (EW'(rdata_reg.epoch) == EW'(hepoch_reg));
        epoch_inc   = rdata_reg.epoch + EPOCH_ONE;
        epoch_rel   = (epoch_inc == '0) ? EPOCH_ONE : epoch_inc;
        epoch_reuse = (rdata_reg.epoch == '0) ? EPOCH_ONE : rdata_reg.epoch;
    end

    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.scan_end  = (ptr_reg >= hw_reg);
    assign status.slot_free = !rdata_reg.busy;

    // Command execution
    always_comb
    begin
        ptr_next   = ptr_reg;
        hw_next    = hw_reg;
        hint_next  = hint_reg;
        mem_we     = 1'b0;
        mem_waddr  = ptr_reg[SLOT_W-1:0];
        mem_wdata  = '0;
        res_load   = 1'b0;
        res_ok     = 1'b0;
        res_slot   = '0;
        res_epoch  = '0;
        res_count  = '0;
        res_stride = '0;

        if (cmd.load)
        begin
            if (command == CMD_ADD)
            begin
                ptr_next = hint_reg;
            end
            else
            begin
                ptr_next = CNT_W'(SW'(handle_slot));
            end
        end

        if (cmd.add_step)
        begin
            ptr_next = ptr_reg + CNT_ONE;
        end

        if (cmd.handle_finish)
        begin
            res_load = 1'b1;
            res_ok   = live;
            if (live && (cmd_reg == CMD_LOOKUP))
            begin
                res_count  = rdata_reg.count;
                res_stride = rdata_reg.stride;
            end
            if (live && (cmd_reg == CMD_RELEASE))
            begin
                mem_we          = 1'b1;
                mem_wdata.epoch = epoch_rel;
                if (hslot_w < hint_w)
                begin
                    hint_next = hslot_w[CNT_W-1:0];
                end
            end
        end

        if (cmd.add_reuse)
        begin
            mem_we           = 1'b1;
            mem_wdata.busy   = 1'b1;
            mem_wdata.epoch  = epoch_reuse;
            mem_wdata.count  = count_reg;
            mem_wdata.stride = stride_reg;
            hint_next        = ptr_reg + CNT_ONE;
            res_load         = 1'b1;
            res_ok           = 1'b1;
            res_slot         = SW'(ptr_reg);
            res_epoch        = epoch_reuse;
        end

        if (cmd.add_append)
        begin
            res_load = 1'b1;
            if (hw_reg != CNT_FULL)
            begin
                mem_we           = 1'b1;
                mem_waddr        = hw_reg[SLOT_W-1:0];
                mem_wdata.busy   = 1'b1;
                mem_wdata.epoch  = EPOCH_ONE;
                mem_wdata.count  = count_reg;
                mem_wdata.stride = stride_reg;
                hw_next          = hw_reg + CNT_ONE;
                hint_next        = hw_reg + CNT_ONE;
                res_ok           = 1'b1;
                res_slot         = SW'(hw_reg);
                res_epoch        = EPOCH_ONE;
            end
        end

        if (cmd.clear)
        begin
            hw_next   = CNT_ONE;
            hint_next = CNT_ONE;
            res_load  = 1'b1;
            res_ok    = 1'b1;
        end

        res_epoch_w = EW'(res_epoch);
    end

    // Slot memory write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Slot memory read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[ptr_next[SLOT_W-1:0]];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_type_reg  <= 8'd1;
            hw_reg        <= CNT_ONE;
            hint_reg      <= CNT_ONE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                exp_type_reg <= cfg_wr_data;
            end
            hw_reg   <= hw_next;
            hint_reg <= hint_next;
            ptr_reg  <= ptr_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latched input beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= command;
            hslot_reg  <= handle_slot;
            hepoch_reg <= handle_epoch;
            htype_reg  <= handle_type;
            count_reg  <= item_count;
            stride_reg <= item_stride;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            ok_reg      <= res_ok;
            slot_reg    <= res_slot[5:0];
            epoch_reg   <= res_epoch_w[15:0];
            ocount_reg  <= res_count;
            ostride_reg <= res_stride;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign out_slot        = slot_reg;
    assign out_epoch       = epoch_reg;
    assign out_item_count  = ocount_reg;
    assign out_item_stride = ostride_reg;

endmodule

// ===== design/generational_handle_slot_table.sv =====
// Top level of the generational handle slot table: controller plus datapath.
//
//  channel  direction  handshake             payload
//  in       receive    in_valid / in_stall   command, handle_slot, handle_epoch,
//                                            handle_type, item_count, item_stride
//  out      send       out_valid / out_stall ok, out_slot, out_epoch,
//                                            out_item_count, out_item_stride
//  cfg      receive    cfg_wr_en             cfg_wr_data (expected_type)
//
// Lookup and release read one slot, then check the handle (a release also writes back); clear
// resets the mark and hint. Add scans from the lowest-free hint past busy slots, all on the
// single read port of the slot memory; append and the full-table case scan the same way.
// Reset takes effect at once: the high-water mark acts as a fill count, so no clearing pass.
// A result waiting under out_stall holds the finishing step; the next beat is taken once the
// operation before it has moved its result into the output register.
module generational_handle_slot_table
#(
    parameter int NUM_SLOTS  = 64,
    parameter int EPOCH_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [5:0]  handle_slot,
    input  logic [15:0] handle_epoch,
    input  logic [7:0]  handle_type,
    input  logic [31:0] item_count,
    input  logic [15:0] item_stride,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [5:0]  out_slot,
    output logic [15:0] out_epoch,
    output logic [31:0] out_item_count,
    output logic [15:0] out_item_stride
);
    import ghst_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    cmd_code_t  command_code;

    assign command_code = cmd_code_t'(command);

    // Sequencer
    ghst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command_code),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Slot memory and result path
    ghst_datapath
    #(
        .NUM_SLOTS  (NUM_SLOTS),
        .EPOCH_BITS (EPOCH_BITS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .command         (command_code),
        .handle_slot     (handle_slot),
        .handle_epoch    (handle_epoch),
        .handle_type     (handle_type),
        .item_count      (item_count),
        .item_stride     (item_stride),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .ok              (ok),
        .out_slot        (out_slot),
        .out_epoch       (out_epoch),
        .out_item_count  (out_item_count),
        .out_item_stride (out_item_stride)
    );

endmodule

// ===== verif/tb.sv =====
// Testbench for the generational handle slot table: predicted results checked beat by beat.
`timescale 1ns / 100ps

module tb;
    import ghst_pkg::*;

    localparam int TABLE_SLOTS  = 64;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_MAX   = 10;
    localparam int EPOCH_ROUNDS = 32;

    // One predicted result beat
    typedef struct packed {
        logic        ok;
        logic [5:0]  slot;
        logic [15:0] epoch;
        logic [31:0] count;
        logic [15:0] stride;
    } slot_result_t;

    // Block ports
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [7:0]  cfg_wr_data   = 8'h00;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  command       = 2'b00;
    logic [5:0]  handle_slot   = 6'd0;
    logic [15:0] handle_epoch  = 16'd0;
    logic [7:0]  handle_type   = 8'd0;
    logic [31:0] item_count    = 32'd0;
    logic [15:0] item_stride   = 16'd0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic        ok;
    logic [5:0]  out_slot;
    logic [15:0] out_epoch;
    logic [31:0] out_item_count;
    logic [15:0] out_item_stride;

    // Shadow copy of the slot table and the type register
    bit          tbl_busy   [TABLE_SLOTS];
    bit [15:0]   tbl_epoch  [TABLE_SLOTS];
    bit [31:0]   tbl_count  [TABLE_SLOTS];
    bit [15:0]   tbl_stride [TABLE_SLOTS];
    int          tbl_mark;
    bit [7:0]    cur_type;

    slot_result_t expected_results [$];

    // Sender pacing and receiver stall pattern
    int burst_left  = 0;
    bit valid_held  = 1'b0;
    bit fast_mode   = 1'b0;
    bit stalls_off  = 1'b0;
    int stall_mode  = 0;
    int stall_left  = 0;

    // Run statistics
    int cmd_seen [4];
    int full_adds       = 0;
    int epoch_wraps     = 0;
    int cfg_writes      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    generational_handle_slot_table #(
        .NUM_SLOTS  (TABLE_SLOTS),
        .EPOCH_BITS (16)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .handle_slot     (handle_slot),
        .handle_epoch    (handle_epoch),
        .handle_type     (handle_type),
        .item_count      (item_count),
        .item_stride     (item_stride),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ok              (ok),
        .out_slot        (out_slot),
        .out_epoch       (out_epoch),
        .out_item_count  (out_item_count),
        .out_item_stride (out_item_stride)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Table predictor
    // ---------------------------------------------------------------

    function automatic void clear_shadow_table();
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            tbl_busy[s]   = 1'b0;
            tbl_epoch[s]  = 16'd0;
            tbl_count[s]  = 32'd0;
            tbl_stride[s] = 16'd0;
        end
        tbl_mark = 1;
    endfunction

    // Live handle: nonzero epoch, right type, slot inside the mark, busy, epoch match
    function automatic bit handle_matches(logic [5:0] hs, logic [15:0] he, logic [7:0] ht);
        return he != 16'd0 && ht == cur_type && hs != 6'd0 && int'(hs) < tbl_mark
               && tbl_busy[hs] && tbl_epoch[hs] == he;
    endfunction

    function automatic slot_result_t predict_table_op(cmd_code_t cmd, logic [5:0] hs,
                                                      logic [15:0] he, logic [7:0] ht,
                                                      logic [31:0] cnt, logic [15:0] str);
        slot_result_t r;
        int           pick;
        bit [15:0]    nxt;
        r    = '0;
        pick = 0;
        case (cmd)
            CMD_ADD:
            begin
                // lowest free slot below the mark, else append
                for (int s = 1; s < tbl_mark && pick == 0; s++)
                begin
                    if (!tbl_busy[s])
                        pick = s;
                end
                if (pick != 0)
                begin
                    if (tbl_epoch[pick] == 16'd0)
                        tbl_epoch[pick] = 16'd1;
                end
                else if (tbl_mark < TABLE_SLOTS)
                begin
                    pick = tbl_mark;
                    tbl_epoch[pick] = 16'd1;
                    tbl_mark++;
                end
                if (pick != 0)
                begin
                    tbl_busy[pick]   = 1'b1;
                    tbl_count[pick]  = cnt;
                    tbl_stride[pick] = str;
                    r.ok    = 1'b1;
                    r.slot  = 6'(pick);
                    r.epoch = tbl_epoch[pick];
                end
                else
                    full_adds++;
            end
            CMD_LOOKUP:
            begin
                if (handle_matches(hs, he, ht))
                begin
                    r.ok     = 1'b1;
                    r.count  = tbl_count[hs];
                    r.stride = tbl_stride[hs];
                end
            end
            CMD_RELEASE:
            begin
                if (handle_matches(hs, he, ht))
                begin
                    tbl_busy[hs]   = 1'b0;
                    tbl_count[hs]  = 32'd0;
                    tbl_stride[hs] = 16'd0;
                    // epoch wraps past zero to one
                    nxt = tbl_epoch[hs] + 16'd1;
                    if (nxt == 16'd0)
                    begin
                        nxt = 16'd1;
                        epoch_wraps++;
                    end
                    tbl_epoch[hs] = nxt;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                clear_shadow_table();
                r.ok = 1'b1;
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Random field helpers
    // ---------------------------------------------------------------

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_stride();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_live_slot();
        int live [$];
        for (int s = 1; s < tbl_mark; s++)
        begin
            if (tbl_busy[s])
                live = {live, s};
        end
        if (live.size() == 0)
            return 0;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // ---------------------------------------------------------------
    // Input channel
    // ---------------------------------------------------------------

    // Drive one beat, wait for acceptance, record the prediction, then maybe idle
    task automatic send_cmd(cmd_code_t cmd, logic [5:0] hs, logic [15:0] he,
                            logic [7:0] ht, logic [31:0] cnt, logic [15:0] str);
        int           gap;
        slot_result_t pred;
        if (!valid_held)
            in_valid <= 1'b1;
        valid_held = 1'b1;
        command      <= cmd;
        handle_slot  <= hs;
        handle_epoch <= he;
        handle_type  <= ht;
        item_count   <= cnt;
        item_stride  <= str;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pred = predict_table_op(cmd, hs, he, ht, cnt, str);
        expected_results = {expected_results, pred};
        cmd_seen[cmd]++;
        burst_left--;
        // end of burst: drop valid for a random gap
        if (!fast_mode && burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            valid_held = 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // Stop sending and wait until every predicted result has arrived
    task automatic hold_until_drained();
        if (valid_held)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Type register write, only with the block idle
    task automatic set_expected_type(logic [7:0] value);
        hold_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_type = value;
        cfg_writes++;
    endtask

    // ---------------------------------------------------------------
    // Output channel
    // ---------------------------------------------------------------

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: result %0d %s mismatch: expected %h, got %h",
                         $time, results_checked, field, want, got);
        end
    endfunction

    // Receiver stall pattern: quiet, sparse, heavy or solid stretches
    always @(posedge clk)
    begin
        if (stalls_off)
            out_stall <= 1'b0;
        else
        begin
            if (stall_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = (stall_mode == 3) ? $urandom_range(1, 30) : $urandom_range(10, 80);
            end
            stall_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= 1'b1;
            endcase
        end
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        slot_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result beat with nothing predicted", $time);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("ok", want.ok, ok);
                check_field("out_slot", want.slot, out_slot);
                check_field("out_epoch", want.epoch, out_epoch);
                check_field("out_item_count", want.count, out_item_count);
                check_field("out_item_stride", want.stride, out_item_stride);
                results_checked++;
            end
        end
    end

    // Watchdog: too long without any beat on either channel
    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Field extremes, every command and each rejection reason, reset type 1
    task automatic test_directed();
        send_cmd(CMD_LOOKUP, 6'd0, 16'd1, 8'h01, 32'd0, 16'd0);           // slot zero
        send_cmd(CMD_RELEASE, 6'd1, 16'd1, 8'h01, 32'd0, 16'd0);          // empty table
        send_cmd(CMD_ADD, 6'd63, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_ADD, 6'd0, 16'd0, 8'h00, 32'd0, 16'd0);
        send_cmd(CMD_ADD, 6'd21, 16'h5A5A, 8'hA5, 32'hA5A5_5A5A, 16'h5AA5);
        send_cmd(CMD_LOOKUP, 6'd1, 16'd1, 8'h01, 32'd0, 16'd0);           // max payload
        send_cmd(CMD_LOOKUP, 6'd2, 16'd1, 8'h01, 32'hFFFF_FFFF, 16'hFFFF); // zero payload
        send_cmd(CMD_LOOKUP, 6'd1, 16'd1, 8'hFF, 32'd0, 16'd0);           // wrong type
        send_cmd(CMD_LOOKUP, 6'd1, 16'd0, 8'h01, 32'd0, 16'd0);           // zero epoch
        send_cmd(CMD_LOOKUP, 6'd4, 16'd1, 8'h01, 32'd0, 16'd0);           // at the mark
        send_cmd(CMD_LOOKUP, 6'd63, 16'hFFFF, 8'hFF, 32'd0, 16'd0);       // above the mark
        send_cmd(CMD_LOOKUP, 6'd1, 16'd2, 8'h01, 32'd0, 16'd0);           // epoch mismatch
        send_cmd(CMD_RELEASE, 6'd2, 16'd1, 8'h01, 32'd0, 16'd0);
        send_cmd(CMD_LOOKUP, 6'd2, 16'd1, 8'h01, 32'd0, 16'd0);           // stale handle
        send_cmd(CMD_RELEASE, 6'd2, 16'd1, 8'h01, 32'd0, 16'd0);          // double release
        send_cmd(CMD_ADD, 6'd0, 16'd0, 8'h00, 32'h0000_0001, 16'h8000);   // reuse, epoch 2
        send_cmd(CMD_LOOKUP, 6'd2, 16'd2, 8'h01, 32'd0, 16'd0);
        send_cmd(CMD_RELEASE, 6'd3, 16'd1, 8'h00, 32'd0, 16'd0);          // wrong type
        send_cmd(CMD_CLEAR, 6'd63, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_LOOKUP, 6'd1, 16'd1, 8'h01, 32'd0, 16'd0);           // gone after clear
        send_cmd(CMD_ADD, 6'd0, 16'd0, 8'h00, 32'h8000_0000, 16'h0001);
        send_cmd(CMD_LOOKUP, 6'd1, 16'd1, 8'h01, 32'd0, 16'd0);
    endtask

    // Fill every slot from one up, hit the full table, then reuse a freed slot
    task automatic test_table_full();
        send_cmd(CMD_CLEAR, 6'd0, 16'd0, 8'h00, 32'd0, 16'd0);
        for (int i = 1; i < TABLE_SLOTS; i++)
            send_cmd(CMD_ADD, 6'($urandom), 16'($urandom), 8'($urandom),
                     pick_count(), pick_stride());
        send_cmd(CMD_ADD, 6'd0, 16'd0, 8'h00, pick_count(), pick_stride());
        send_cmd(CMD_ADD, 6'd63, 16'hFFFF, 8'hFF, pick_count(), pick_stride());
        send_cmd(CMD_LOOKUP, 6'd63, 16'd1, cur_type, 32'd0, 16'd0);
        send_cmd(CMD_LOOKUP, 6'd63, 16'd2, cur_type, 32'd0, 16'd0);
        send_cmd(CMD_RELEASE, 6'd40, 16'd1, cur_type, 32'd0, 16'd0);
        send_cmd(CMD_ADD, 6'd0, 16'd0, 8'h00, pick_count(), pick_stride());
        send_cmd(CMD_ADD, 6'd0, 16'd0, 8'h00, pick_count(), pick_stride());
        send_cmd(CMD_LOOKUP, 6'd40, 16'd2, cur_type, 32'd0, 16'd0);
        send_cmd(CMD_RELEASE, 6'd63, 16'd1, cur_type, 32'd0, 16'd0);
        send_cmd(CMD_LOOKUP, 6'd63, 16'd1, cur_type, 32'd0, 16'd0);
    endtask

    // Cycle one slot through a run of epochs, checking stale handles on the way
    task automatic test_epoch_cycle();
        bit [15:0] old_epoch;
        fast_mode  = 1'b1;
        stalls_off = 1'b1;
        send_cmd(CMD_CLEAR, 6'd0, 16'd0, 8'h00, 32'd0, 16'd0);
        send_cmd(CMD_ADD, 6'd0, 16'd0, 8'h00, pick_count(), pick_stride());
        for (int i = 0; i < EPOCH_ROUNDS; i++)
        begin
            old_epoch = tbl_epoch[1];
            send_cmd(CMD_RELEASE, 6'd1, old_epoch, cur_type, 32'd0, 16'd0);
            send_cmd(CMD_ADD, 6'd0, 16'd0, 8'h00, pick_count(), pick_stride());
            if (i % 8 == 0)
                send_cmd(CMD_LOOKUP, 6'd1, old_epoch, cur_type, 32'd0, 16'd0); // stale
        end
        send_cmd(CMD_LOOKUP, 6'd1, tbl_epoch[1], cur_type, 32'd0, 16'd0);     // live
        fast_mode  = 1'b0;
        stalls_off = 1'b0;
        hold_until_drained();
    endtask

    // Malformed handle: stale epoch, wrong type, zero epoch, slot zero, past the mark, noise
    task automatic send_broken_handle();
        cmd_code_t   cmd;
        int          kind;
        logic [5:0]  hs;
        logic [15:0] he;
        logic [7:0]  ht;
        cmd  = ($urandom_range(0, 1) == 0) ? CMD_LOOKUP : CMD_RELEASE;
        kind = $urandom_range(0, 5);
        hs   = 6'($urandom_range(1, 63));
        he   = tbl_epoch[hs];
        ht   = cur_type;
        case (kind)
            0: he = tbl_epoch[hs] + (($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF);
            1:
            begin
                if (tbl_mark > 1)
                    hs = 6'($urandom_range(1, tbl_mark - 1));
                he = tbl_epoch[hs];
                ht = cur_type ^ 8'($urandom_range(1, 255));
            end
            2: he = 16'd0;
            3:
            begin
                hs = 6'd0;
                he = 16'($urandom_range(1, 65535));
            end
            4:
            begin
                hs = (tbl_mark < TABLE_SLOTS) ? 6'($urandom_range(tbl_mark, 63)) : 6'd63;
                he = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom);
            end
            default:
            begin
                hs = 6'($urandom);
                he = 16'($urandom);
                ht = 8'($urandom);
            end
        endcase
        send_cmd(cmd, hs, he, ht, pick_count(), pick_stride());
    endtask

    // Mostly well-formed traffic on live handles, with some malformed beats
    task automatic test_random_traffic(int n_items, int add_pct, int clear_pct);
        int r;
        int s;
        int k;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < clear_pct)
                send_cmd(CMD_CLEAR, 6'($urandom), 16'($urandom), 8'($urandom),
                         pick_count(), pick_stride());
            else if (r < clear_pct + add_pct)
                send_cmd(CMD_ADD, 6'($urandom), 16'($urandom), 8'($urandom),
                         pick_count(), pick_stride());
            else
            begin
                s = pick_live_slot();
                k = $urandom_range(0, 9);
                if (s == 0 || k >= 8)
                    send_broken_handle();
                else if (k < 5)
                    send_cmd(CMD_LOOKUP, 6'(s), tbl_epoch[s], cur_type,
                             $urandom, 16'($urandom));
                else
                    send_cmd(CMD_RELEASE, 6'(s), tbl_epoch[s], cur_type,
                             $urandom, 16'($urandom));
            end
            // occasional full drain of the pipeline
            if ($urandom_range(0, 149) == 0)
                hold_until_drained();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        clear_shadow_table();
        cur_type = 8'h01;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_expected_type(8'hFF);
        test_table_full();
        test_epoch_cycle();

        set_expected_type(8'h00);
        test_random_traffic(350, 60, 1);
        set_expected_type(8'($urandom_range(2, 254)));
        test_random_traffic(350, 35, 3);
        set_expected_type(8'hFF);
        test_random_traffic(350, 20, 1);
        set_expected_type(8'h01);
        test_random_traffic(330, 50, 1);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d add, %0d lookup, %0d release, %0d clear commands; %0d results",
                 cmd_seen[CMD_ADD], cmd_seen[CMD_LOOKUP], cmd_seen[CMD_RELEASE],
                 cmd_seen[CMD_CLEAR], results_checked);
        $display("Full-table adds %0d, epoch wraps %0d, type writes %0d, mismatches %0d",
                 full_adds, epoch_wraps, cfg_writes, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
